/* src/arm64_prologue_detector_core_macros.svh */
// Assertion macros for the prologue detector.
// Included by files that carry concurrent checks; depends on nothing else.
`ifndef ARM64_PROLOGUE_DETECTOR_CORE_MACROS_SVH
`define ARM64_PROLOGUE_DETECTOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define APD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define APD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/apd_pkg.sv */
// Shared constants, types and helpers for the prologue detector.
// No dependencies; imported by every other file of the block but the macro header.
package apd_pkg;

  localparam int unsigned ADDR_WIDTH = 64;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned PORT_ADDR_W = 64;

  localparam logic [WORD_W-1:0] PAC_MASK   = 32'hFFFF_FFBF;
  localparam logic [WORD_W-1:0] PAC_MATCH  = 32'hD503_233F;
  localparam logic [WORD_W-1:0] SUB_MASK   = 32'hFF00_03FF;
  localparam logic [WORD_W-1:0] SUB_MATCH  = 32'hD100_03FF;
  localparam logic [WORD_W-1:0] STP_MASK   = 32'hFF40_03E0;
  localparam logic [WORD_W-1:0] STPX_MATCH = 32'hA900_03E0;
  localparam logic [WORD_W-1:0] STPD_MATCH = 32'h6D00_03E0;
  localparam logic [WORD_W-1:0] ADD_MASK   = 32'hFF00_03FF;
  localparam logic [WORD_W-1:0] ADD_MATCH  = 32'h9100_03FD;

  typedef logic [ADDR_WIDTH-1:0] addr_t;

  // Raw pattern hits of one instruction word, before priority is applied.
  typedef struct packed {
    logic pac;
    logic sub;
    logic stpx;
    logic stpd;
    logic add;
  } match_t;

  // Zero-extends a kept address to the port width.
  function automatic logic [PORT_ADDR_W-1:0] widen_addr(input addr_t a);
    logic [PORT_ADDR_W-1:0] r;
    r = '0;
    r[ADDR_WIDTH-1:0] = a;
    return r;
  endfunction

endpackage

/* src/apd_if.sv */
// Valid/ready channel interfaces for the prologue detector.
// Depends on apd_pkg for the field widths.
interface apd_in_if;
  import apd_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [WORD_W-1:0]      instr_word;
  logic [PORT_ADDR_W-1:0] instr_address;
  logic                   region_start;

  modport source (output valid, instr_word, instr_address, region_start, input ready);
  modport sink   (input valid, instr_word, instr_address, region_start, output ready);
endinterface

interface apd_out_if;
  import apd_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [PORT_ADDR_W-1:0] entry_addr;

  modport source (output valid, entry_addr, input ready);
  modport sink   (input valid, entry_addr, output ready);
endinterface

/* src/apd_classify.sv */
// Instruction word classifier: masked compares against the prologue patterns.
// Depends on apd_pkg.
module apd_classify (
  input  logic [apd_pkg::WORD_W-1:0] word_i,
  output apd_pkg::match_t            match_o
);
  import apd_pkg::*;

  always_comb begin
    match_o.pac  = (word_i & PAC_MASK) == PAC_MATCH;
    match_o.sub  = (word_i & SUB_MASK) == SUB_MATCH;
    match_o.stpx = (word_i & STP_MASK) == STPX_MATCH;
    match_o.stpd = (word_i & STP_MASK) == STPD_MATCH;
    match_o.add  = (word_i & ADD_MASK) == ADD_MATCH;
  end

endmodule

/* src/arm64_prologue_detector_core.sv */
// AArch64 function prologue detector, top level.
// Depends on apd_pkg, apd_if.sv, apd_classify and the assertion macro header.
//
// Usage:
// The in_i channel carries one instruction beat: the 32-bit word, its byte
// address and a flag that marks the first word of a new executable region.
// The out_o channel carries one beat per completed prologue: the address at
// which the function begins. Most words produce no output beat.
// An accepted input beat goes first into the input register and then into the
// result register, from which its output beat is offered; a beat with a result
// waits in the input register while the result register holds an untaken result.
// Throughput is one input beat per cycle unless the receiver stalls; the only
// thing that sets it is the flag and candidate update, a handful of masked
// compares and muxes. When the receiver stalls, a waiting result holds in the
// result register and the input register still takes beats; each moves on at
// once if it has no result, and otherwise waits until the result is taken.
// Reset clears both stage valid bits, the three pattern flags and the
// candidate address, so the first beat after reset starts from a clean scan.
// Only the low ADDR_WIDTH address bits are kept; upper output bits read zero.
module arm64_prologue_detector_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  apd_in_if.sink     in_i,
  apd_out_if.source  out_o
);
  import apd_pkg::*;

  `include "arm64_prologue_detector_core_macros.svh"

  // Input register stage.
  logic              in_vld_q;
  logic [WORD_W-1:0] word_q;
  addr_t             addr_q;
  logic              region_q;

  // Scan state.
  logic  auth_q, auth_d;
  logic  sub_q, sub_d;
  logic  pair_q, pair_d;
  addr_t cand_q, cand_d;

  // Result register stage.
  logic  out_vld_q;
  addr_t res_q;

  match_t match;
  logic   emit;
  logic   advance;
  logic   a0, s0, p0;
  addr_t  c0;

  apd_classify u_classify (
    .word_i  (word_q),
    .match_o (match)
  );

  // Next scan state for the word in the input register. A region start wipes
  // the state before the word is looked at; the tests then run in priority
  // order. Note the d-register store latches the address even after a PAC
  // sign, unlike the x-register store.
  always_comb begin
    a0 = region_q ? 1'b0 : auth_q;
    s0 = region_q ? 1'b0 : sub_q;
    p0 = region_q ? 1'b0 : pair_q;
    c0 = region_q ? '0   : cand_q;
    auth_d = a0;
    sub_d  = s0;
    pair_d = p0;
    cand_d = c0;
    emit   = 1'b0;
    priority if (!a0 && match.pac) begin
      cand_d = addr_q;
      auth_d = 1'b1;
      sub_d  = 1'b0;
      pair_d = 1'b0;
    end else if (!s0 && match.sub) begin
      if (!a0) begin
        cand_d = addr_q;
      end
      sub_d  = 1'b1;
      pair_d = 1'b0;
    end else if (match.stpx) begin
      if (!a0 && !s0 && !p0) begin
        cand_d = addr_q;
      end
      pair_d = 1'b1;
    end else if (match.stpd) begin
      if (!s0 && !p0) begin
        cand_d = addr_q;
      end
      pair_d = 1'b1;
    end else if (p0 && match.add) begin
      // Frame setup completes the prologue; the candidate survives.
      emit   = 1'b1;
      auth_d = 1'b0;
      sub_d  = 1'b0;
      pair_d = 1'b0;
    end else begin
      // A word that fits no pattern the current state accepts drops a scan in progress.
      if (a0 || s0 || p0) begin
        auth_d = 1'b0;
        sub_d  = 1'b0;
        pair_d = 1'b0;
        cand_d = '0;
      end
    end
  end

  // The held word moves on unless it has a result and the result slot is busy.
  assign advance    = in_vld_q && (!emit || !out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      word_q   <= in_i.instr_word;
      addr_q   <= in_i.instr_address[ADDR_WIDTH-1:0];
      region_q <= in_i.region_start;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auth_q <= 1'b0;
      sub_q  <= 1'b0;
      pair_q <= 1'b0;
      cand_q <= '0;
    end else if (advance) begin
      auth_q <= auth_d;
      sub_q  <= sub_d;
      pair_q <= pair_d;
      cand_q <= cand_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && emit) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      res_q <= c0;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.entry_addr = widen_addr(res_q);

  // A result is only produced from a state that had seen a pair store.
  `APD_ASSERT_IMP(a_emit_needs_pair, clk_i, rst_ni, advance && emit, p0)
  // A completed prologue leaves all pattern flags clear.
  `APD_ASSERT_NXT(a_emit_clears_flags, clk_i, rst_ni, advance && emit, !auth_q && !sub_q && !pair_q)
  // A held word that could not move on is still there next cycle.
  `APD_ASSERT_NXT(a_hold_keeps_item, clk_i, rst_ni, in_vld_q && !advance, in_vld_q)
  // A result never overwrites one that the receiver has not taken.
  `APD_ASSERT_IMP(a_no_result_overrun, clk_i, rst_ni, advance && emit && out_vld_q, out_o.ready)

endmodule
